### hdl/masked_shifted_sprite_blit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sprite blitter
// Both macros sample on clk and stay quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_SHIFTED_SPRITE_BLIT_ASSERT_SVH
`define MASKED_SHIFTED_SPRITE_BLIT_ASSERT_SVH

// Same-cycle implication.
`define MSB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types, defaults and constants of the masked sprite blitter.
// ----------------------------------------------------------------------------
package msb_pkg;

  // Default geometry of the frame store.
  localparam int ROW_BYTES_DEF = 32;
  localparam int ROWS_DEF      = 200;
  localparam int PLANES_DEF    = 3;

  // Fixed field widths of the item channels.
  localparam int ADDR_IN_W = 13;

  // Decode constants.
  localparam logic [7:0]        WIDTH_MASK = 8'h3f;
  localparam logic [7:0]        NIB_HI     = 8'hf0;
  localparam logic [7:0]        NIB_LO     = 8'h0f;
  localparam logic [7:0]        SHIFT_MASK = 8'h07;
  localparam logic signed [9:0] TOP_ROW    = 10'sd191;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PAIR  = 2'd1,
    OP_READ  = 2'd2
  } msb_op_t;

  // Controller state: clearing pass after reset, then normal operation.
  typedef enum logic {
    MSB_CLEAR = 1'b0,
    MSB_RUN   = 1'b1
  } msb_state_t;

  // Sprite settings that steer the pair encoder.
  typedef struct packed {
    logic       gfx_mode;
    logic [2:0] bit_shift;
    logic [2:0] plane_enable;
    logic       cpc_promote;
  } msb_pair_ctl_t;

endpackage

### hdl/msb_in_if.sv
// ----------------------------------------------------------------------------
// msb_in_if
// Input item channel: start, byte pair and read items.
// ----------------------------------------------------------------------------
interface msb_in_if import msb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [7:0]           pixel_x;
  logic [7:0]           pixel_y;
  logic [7:0]           header_width;
  logic [7:0]           header_height;
  logic [7:0]           cpc_flag;
  logic [2:0]           sprite_attr;
  logic [7:0]           byte_a;
  logic [7:0]           byte_b;
  logic [ADDR_IN_W-1:0] read_address;

  modport source (
    output valid, op, pixel_x, pixel_y, header_width, header_height,
           cpc_flag, sprite_attr, byte_a, byte_b, read_address,
    input  ready
  );

  modport sink (
    input  valid, op, pixel_x, pixel_y, header_width, header_height,
           cpc_flag, sprite_attr, byte_a, byte_b, read_address,
    output ready
  );
endinterface

### hdl/msb_out_if.sv
// ----------------------------------------------------------------------------
// msb_out_if
// Result item channel: one frame store word with all planes.
// ----------------------------------------------------------------------------
interface msb_out_if import msb_pkg::*; #(
  parameter int PLANES = PLANES_DEF
);
  logic                  valid;
  logic                  ready;
  logic [8*PLANES-1:0]   read_planes;

  modport source (output valid, read_planes, input ready);
  modport sink   (input valid, read_planes, output ready);
endinterface

### hdl/msb_cfg_if.sv
// ----------------------------------------------------------------------------
// msb_cfg_if
// Configuration write channel for the graphics mode register.
// ----------------------------------------------------------------------------
interface msb_cfg_if import msb_pkg::*;;
  logic valid;
  logic ready;
  logic gfx_mode;

  modport source (output valid, gfx_mode, input ready);
  modport sink   (input valid, gfx_mode, output ready);
endinterface

### hdl/msb_ram.sv
// ----------------------------------------------------------------------------
// msb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msb_ram import msb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/msb_pair_enc.sv
// ----------------------------------------------------------------------------
// msb_pair_enc
// Turns one byte pair into per-plane mask and data words for the word at the
// pointer and for the word after it, including the right shift by x mod 8.
// ----------------------------------------------------------------------------
module msb_pair_enc import msb_pkg::*; #(
  parameter int PLANES = PLANES_DEF
) (
  input  msb_pair_ctl_t        ctl,
  input  logic [7:0]           byte_a,
  input  logic [7:0]           byte_b,
  output logic [8*PLANES-1:0]  mask_w0,
  output logic [8*PLANES-1:0]  data_w0,
  output logic [8*PLANES-1:0]  mask_w1,
  output logic [8*PLANES-1:0]  data_w1
);

  logic [7:0]        cpc_d0;
  logic [7:0]        cpc_d1;
  logic [7:0]        cpc_m;
  logic [PLANES+2:0] pe_wide;

  assign pe_wide = {PLANES'(0), ctl.plane_enable};

  // Two-plane nibble decode; clear overlaps, or promote plane-0-only bits.
  always_comb begin
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] c1;
    logic [7:0] c3;
    d1 = (byte_a & NIB_HI) | (byte_b >> 4);
    d0 = 8'((byte_a << 4) | (byte_b & NIB_LO));
    c1 = d0 & ~d1;
    c3 = d1 & d0;
    cpc_m = d1 | d0;
    if (ctl.cpc_promote) begin
      d1 = d1 | c1;
    end else begin
      d1 = d1 & ~c3;
      d0 = d0 & ~c3;
    end
    cpc_d0 = d0;
    cpc_d1 = d1;
  end

  // Per plane: pick mask and data, then split them across two words.
  always_comb begin
    logic [7:0]  pm;
    logic [7:0]  pd;
    logic [15:0] sm;
    logic [15:0] sd;
    for (int n = 0; n < PLANES; n++) begin
      if (!ctl.gfx_mode) begin
        pm = byte_a;
        pd = pe_wide[n] ? byte_b : 8'h00;
      end else if (n == 0) begin
        pm = cpc_m;
        pd = cpc_d0;
      end else if (n == 1) begin
        pm = cpc_m;
        pd = cpc_d1;
      end else begin
        pm = 8'h00;
        pd = 8'h00;
      end
      sm = {pm, 8'h00} >> ctl.bit_shift;
      sd = {pd, 8'h00} >> ctl.bit_shift;
      mask_w0[8*n +: 8] = sm[15:8];
      data_w0[8*n +: 8] = sd[15:8];
      mask_w1[8*n +: 8] = sm[7:0];
      data_w1[8*n +: 8] = sd[7:0];
    end
  end

endmodule

### hdl/masked_shifted_sprite_blit.sv
// ----------------------------------------------------------------------------
// masked_shifted_sprite_blit: planar sprite blitter over one frame store RAM.
// A pair with x mod 8 nonzero touches two words and holds off the next item,
// since each touched word needs its own read-modify-write on the RAM port.
// Read results pass the access stage into the result buffer; reads stall
// while two are pending. Reset clears all ROWS*ROW_BYTES words (6400) first.
// ----------------------------------------------------------------------------
`include "masked_shifted_sprite_blit_assert.svh"

module masked_shifted_sprite_blit import msb_pkg::*; #(
  parameter int ROW_BYTES = ROW_BYTES_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int PLANES    = PLANES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch,
  msb_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = ROW_BYTES * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 8 * PLANES;
  localparam int PTR_W = $clog2(320 * ROW_BYTES + 16384) + 2;

  localparam logic signed [PTR_W-1:0] DEPTH_S     = PTR_W'(DEPTH);
  localparam logic signed [PTR_W-1:0] ROW_BYTES_S = PTR_W'(ROW_BYTES);
  localparam logic signed [PTR_W-1:0] ONE_S       = PTR_W'(1);

  // True when a linear pointer lies inside the frame store.
  function automatic logic in_store(input logic signed [PTR_W-1:0] p);
    return (p >= 0) && (p < DEPTH_S);
  endfunction

  // Controller state and clearing pass.
  msb_state_t state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic clr_busy;

  // Configuration and sprite state.
  logic                    mode_r, mode_nxt;
  logic signed [PTR_W-1:0] wp_r, wp_nxt;
  logic [2:0]              shift_r, shift_nxt;
  logic [5:0]              row_width_r, row_width_nxt;
  logic [5:0]              cols_left_r, cols_left_nxt;
  logic [7:0]              rows_left_r, rows_left_nxt;
  logic [2:0]              pe_r, pe_nxt;
  logic                    promote_r, promote_nxt;

  // Second word of a shifted pair, waiting for the RAM port.
  logic          pend_r, pend_nxt;
  logic          pend_we_r, pend_we_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [WW-1:0] pend_mask_r, pend_mask_nxt;
  logic [WW-1:0] pend_data_r, pend_data_nxt;

  // Access stage: RAM data arrives here, merge and write back.
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_rd_r, s1_rd_nxt;
  logic          s1_we_r, s1_we_nxt;
  logic          s1_rzero_r, s1_rzero_nxt;
  logic [AW-1:0] s1_addr_r, s1_addr_nxt;
  logic [WW-1:0] s1_mask_r, s1_mask_nxt;
  logic [WW-1:0] s1_data_r, s1_data_nxt;

  // Last RAM write, for forwarding over the read-during-write case.
  logic          fw_valid_r, fw_valid_nxt;
  logic [AW-1:0] fw_addr_r, fw_addr_nxt;
  logic [WW-1:0] fw_data_r, fw_data_nxt;

  // Result buffer, two entries.
  logic [1:0]    ocnt_r, ocnt_nxt;
  logic [WW-1:0] ent0_r, ent0_nxt;
  logic [WW-1:0] ent1_r, ent1_nxt;

  // RAM ports and datapath wires.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] ram_rdata;
  logic [WW-1:0] old_word;
  logic [WW-1:0] rd_value;
  logic [1:0]    inflight;
  logic          in_acc;
  logic          out_pop;
  logic          res_push;

  msb_pair_ctl_t enc_ctl;
  logic [WW-1:0] mask_w0, data_w0, mask_w1, data_w1;

  // Controller next state.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      MSB_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = MSB_RUN;
        end
      end
      MSB_RUN: begin
        state_nxt = MSB_RUN;
      end
      default: begin
        state_nxt = MSB_CLEAR;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    unique case (state_r)
      MSB_CLEAR: clr_busy = 1'b1;
      MSB_RUN:   clr_busy = 1'b0;
      default:   clr_busy = 1'b1;
    endcase
  end

  // Handshakes. Reads in flight are bounded by the result buffer depth.
  assign inflight     = {1'b0, s1_valid_r & s1_rd_r} + ocnt_r;
  assign in_ch.ready  = !clr_busy && !pend_r && (inflight < 2'd2);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign mode_nxt     = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.gfx_mode : mode_r;

  assign enc_ctl.gfx_mode     = mode_r;
  assign enc_ctl.bit_shift    = shift_r;
  assign enc_ctl.plane_enable = pe_r;
  assign enc_ctl.cpc_promote  = promote_r;

  msb_pair_enc #(
    .PLANES (PLANES)
  ) u_pair_enc (
    .ctl     (enc_ctl),
    .byte_a  (in_ch.byte_a),
    .byte_b  (in_ch.byte_b),
    .mask_w0 (mask_w0),
    .data_w0 (data_w0),
    .mask_w1 (mask_w1),
    .data_w1 (data_w1)
  );

  // Front end: sprite state updates and issue of RAM accesses.
  always_comb begin
    logic signed [9:0]       start_row;
    logic signed [PTR_W-1:0] wp_inc;
    logic [5:0]              w6;
    logic                    pair_go;
    wp_nxt        = wp_r;
    shift_nxt     = shift_r;
    row_width_nxt = row_width_r;
    cols_left_nxt = cols_left_r;
    rows_left_nxt = rows_left_r;
    pe_nxt        = pe_r;
    promote_nxt   = promote_r;

    pend_nxt      = 1'b0;
    pend_we_nxt   = pend_we_r;
    pend_addr_nxt = pend_addr_r;
    pend_mask_nxt = pend_mask_r;
    pend_data_nxt = pend_data_r;

    s1_valid_nxt  = 1'b0;
    s1_rd_nxt     = 1'b0;
    s1_we_nxt     = 1'b0;
    s1_rzero_nxt  = 1'b0;
    s1_addr_nxt   = pend_addr_r;
    s1_mask_nxt   = pend_mask_r;
    s1_data_nxt   = pend_data_r;

    start_row = TOP_ROW - $signed({2'b00, in_ch.pixel_y});
    wp_inc    = wp_r + ONE_S;
    w6        = 6'(in_ch.header_width & WIDTH_MASK);
    pair_go   = in_acc && (in_ch.op == OP_PAIR) && (rows_left_r != 8'd0);

    priority if (pend_r) begin
      // Second word of the previous pair.
      s1_valid_nxt = 1'b1;
      s1_we_nxt    = pend_we_r;
    end else if (in_acc) begin
      unique case (in_ch.op)
        OP_START: begin
          if (mode_r) begin
            w6 = w6 >> 1;
          end
          wp_nxt = PTR_W'(start_row) * ROW_BYTES_S
                   + $signed(PTR_W'(in_ch.pixel_x >> 3));
          shift_nxt     = 3'(in_ch.pixel_x & SHIFT_MASK);
          row_width_nxt = w6;
          cols_left_nxt = w6;
          rows_left_nxt = (w6 == 6'd0) ? 8'd0 : in_ch.header_height;
          pe_nxt        = in_ch.sprite_attr;
          promote_nxt   = (in_ch.cpc_flag != 8'd0);
        end
        OP_PAIR: begin
          if (pair_go) begin
            s1_valid_nxt = 1'b1;
            s1_we_nxt    = in_store(wp_r);
            s1_addr_nxt  = wp_r[AW-1:0];
            s1_mask_nxt  = mask_w0;
            s1_data_nxt  = data_w0;
            if (shift_r != 3'd0) begin
              pend_nxt      = 1'b1;
              pend_we_nxt   = in_store(wp_inc);
              pend_addr_nxt = wp_inc[AW-1:0];
              pend_mask_nxt = mask_w1;
              pend_data_nxt = data_w1;
            end
            // Step along the row; at its end move up one framebuffer row.
            if (cols_left_r == 6'd1) begin
              wp_nxt = wp_inc - ROW_BYTES_S - $signed(PTR_W'(row_width_r));
              rows_left_nxt = rows_left_r - 8'd1;
              cols_left_nxt = row_width_r;
            end else begin
              wp_nxt        = wp_inc;
              cols_left_nxt = cols_left_r - 6'd1;
            end
          end
        end
        OP_READ: begin
          s1_valid_nxt = 1'b1;
          s1_rd_nxt    = 1'b1;
          s1_rzero_nxt = !(32'(in_ch.read_address) < 32'(DEPTH));
          s1_addr_nxt  = AW'(in_ch.read_address);
        end
        default: begin
          s1_valid_nxt = 1'b0;
        end
      endcase
    end else begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Access stage: forward the word written in the same cycle as our read.
  assign old_word = (fw_valid_r && (fw_addr_r == s1_addr_r)) ? fw_data_r : ram_rdata;
  assign rd_value = s1_rzero_r ? '0 : old_word;

  // RAM write port: clearing pass, else the merged word.
  always_comb begin
    if (clr_busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_valid_r && s1_we_r;
      mem_waddr = s1_addr_r;
      mem_wdata = (old_word & ~s1_mask_r) | s1_data_r;
    end
  end

  assign fw_valid_nxt = mem_we;
  assign fw_addr_nxt  = mem_waddr;
  assign fw_data_nxt  = mem_wdata;

  msb_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (s1_addr_nxt),
    .rdata (ram_rdata)
  );

  // Result buffer: push read results, pop on the output handshake.
  assign res_push = s1_valid_r && s1_rd_r;
  assign out_pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    ocnt_nxt = ocnt_r;
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    priority if (res_push && out_pop) begin
      if (ocnt_r == 2'd1) begin
        ent0_nxt = rd_value;
      end else begin
        ent0_nxt = ent1_r;
        ent1_nxt = rd_value;
      end
    end else if (res_push) begin
      if (ocnt_r == 2'd0) begin
        ent0_nxt = rd_value;
      end else begin
        ent1_nxt = rd_value;
      end
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (out_pop) begin
      ent0_nxt = ent1_r;
      ocnt_nxt = ocnt_r - 2'd1;
    end else begin
      ocnt_nxt = ocnt_r;
    end
  end

  assign out_ch.valid       = (ocnt_r != 2'd0);
  assign out_ch.read_planes = ent0_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= MSB_CLEAR;
      clr_addr_r  <= '0;
      mode_r      <= 1'b0;
      wp_r        <= '0;
      shift_r     <= '0;
      row_width_r <= '0;
      cols_left_r <= '0;
      rows_left_r <= '0;
      pe_r        <= '0;
      promote_r   <= 1'b0;
      pend_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      fw_valid_r  <= 1'b0;
      ocnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      mode_r      <= mode_nxt;
      wp_r        <= wp_nxt;
      shift_r     <= shift_nxt;
      row_width_r <= row_width_nxt;
      cols_left_r <= cols_left_nxt;
      rows_left_r <= rows_left_nxt;
      pe_r        <= pe_nxt;
      promote_r   <= promote_nxt;
      pend_r      <= pend_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fw_valid_r  <= fw_valid_nxt;
      ocnt_r      <= ocnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_we_r   <= pend_we_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_mask_r <= pend_mask_nxt;
    pend_data_r <= pend_data_nxt;
    s1_rd_r     <= s1_rd_nxt;
    s1_we_r     <= s1_we_nxt;
    s1_rzero_r  <= s1_rzero_nxt;
    s1_addr_r   <= s1_addr_nxt;
    s1_mask_r   <= s1_mask_nxt;
    s1_data_r   <= s1_data_nxt;
    fw_addr_r   <= fw_addr_nxt;
    fw_data_r   <= fw_data_nxt;
    ent0_r      <= ent0_nxt;
    ent1_r      <= ent1_nxt;
  end

  // Checks on the access pipeline and the result buffer.
  `MSB_ASSERT_IMP(a_inflight_bound, 1'b1, inflight <= 2'd2,
                  "more reads in flight than the result buffer holds")
  `MSB_ASSERT_NXT(a_pend_single, pend_r, !pend_r,
                  "second word of a pair held for more than one cycle")
  `MSB_ASSERT_IMP(a_no_access_in_clear, state_r == MSB_CLEAR,
                  !s1_valid_r && !pend_r, "RAM access issued during the clearing pass")
  `MSB_ASSERT_NXT(a_read_lands, s1_valid_r && s1_rd_r, ocnt_r != 2'd0,
                  "read result did not reach the result buffer")

endmodule
